### rtl/mmfc_pkg.sv
// ---------------------------------------------------------------------------
// mmfc_pkg
// Shared widths, request codes and reset values for the motor frame codec.
// ---------------------------------------------------------------------------
package mmfc_pkg;

  localparam int POS_BITS_DEF   = 16;
  localparam int FIELD_BITS_DEF = 12;

  // divider geometry: 50-bit dividend, 33-bit divisor, 32-bit quotient
  localparam int DIV_NW = 50;
  localparam int DIV_DW = 33;
  localparam int DIV_QW = 32;

  localparam logic signed [31:0] KP_HIGH = 32'sd32768000;
  localparam logic signed [31:0] KD_HIGH = 32'sd327680;

  // gain divisors: 2*KP_HIGH = 500 << 17, 2*KD_HIGH = 5 << 17
  localparam logic [21:0] KP_RECIP = 22'd2147484;   // ceil(2^30 / 500)
  localparam logic [27:0] KD_RECIP = 28'd214748365; // ceil(2^30 / 5)

  localparam logic signed [31:0] POS_MIN_RST = -32'sd819200;
  localparam logic signed [31:0] POS_MAX_RST = 32'sd819200;
  localparam logic signed [31:0] VEL_MIN_RST = -32'sd1966080;
  localparam logic signed [31:0] VEL_MAX_RST = 32'sd1966080;
  localparam logic signed [31:0] TRQ_MIN_RST = -32'sd655360;
  localparam logic signed [31:0] TRQ_MAX_RST = 32'sd655360;

  typedef enum logic [1:0] {
    REQ_ENC   = 2'd0,
    REQ_DEC   = 2'd1,
    REQ_STATE = 2'd2,
    REQ_RSVD  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    REG_POS_MIN = 3'd0,
    REG_POS_MAX = 3'd1,
    REG_VEL_MIN = 3'd2,
    REG_VEL_MAX = 3'd3,
    REG_TRQ_MIN = 3'd4,
    REG_TRQ_MAX = 3'd5,
    REG_NONE6   = 3'd6,
    REG_NONE7   = 3'd7
  } reg_idx_t;

endpackage

### rtl/mmfc_div.sv
// ---------------------------------------------------------------------------
// mmfc_div
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// ---------------------------------------------------------------------------
module mmfc_div #(
  parameter int NW = mmfc_pkg::DIV_NW,
  parameter int DW = mmfc_pkg::DIV_DW,
  parameter int QW = mmfc_pkg::DIV_QW
) (
  input  logic          clk,
  input  logic [QW-1:0] en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);
  import mmfc_pkg::*;

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [NW-1:0] rem_prev, sub, sh;
    logic [DW-1:0] den_prev;
    logic [QW-1:0] quo_prev, quo_new;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_prev = num;
      assign den_prev = den;
      assign quo_prev = '0;
    end else begin : g_rest
      assign rem_prev = rem_q[k-1];
      assign den_prev = den_q[k-1];
      assign quo_prev = quo_q[k-1];
    end

    always_comb begin
      sh      = rem_prev >> B;
      sub     = {{(NW-DW){1'b0}}, den_prev} << B;
      take    = sh >= {{(NW-DW){1'b0}}, den_prev};
      quo_new = quo_prev;
      quo_new[B] = take;
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_q[k] <= take ? rem_prev - sub : rem_prev;
        den_q[k] <= den_prev;
        quo_q[k] <= quo_new;
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

### rtl/mit_motor_frame_codec.sv
// ---------------------------------------------------------------------------
// mit_motor_frame_codec
// Encode/decode of 8-byte motor CAN frames with Q16.16 scaling.
//
//   channel | dir | handshake          | payload
//   in      | in  | in_valid/in_stall  | req_type, cmd_*, frame_in, state_command
//   out     | out | out_valid/out_stall| ok, frame_out, fb_*, mos_temp, rotor_temp
//   cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word per cycle while out_stall is low; stages: prep, multiply, 32 divider steps,
// output register. The 32-step quotient pipeline sets the depth; kp and kd
// codes come from a reciprocal multiply in stage 2 and ride the side data.
// Each stage moves on when it is empty or the stage after it moves, so
// bubbles collapse under out_stall. Sync reset clears valids and resets config.
// ---------------------------------------------------------------------------
module mit_motor_frame_codec #(
  parameter int POS_BITS   = mmfc_pkg::POS_BITS_DEF,
  parameter int FIELD_BITS = mmfc_pkg::FIELD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] cmd_position,
  input  logic signed [31:0] cmd_velocity,
  input  logic signed [31:0] cmd_kp,
  input  logic signed [31:0] cmd_kd,
  input  logic signed [31:0] cmd_torque,
  input  logic [63:0]        frame_in,
  input  logic [7:0]         state_command,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               ok,
  output logic [63:0]        frame_out,
  output logic [3:0]         fb_state,
  output logic signed [31:0] fb_position,
  output logic signed [31:0] fb_velocity,
  output logic signed [31:0] fb_torque,
  output logic [7:0]         mos_temp,
  output logic [7:0]         rotor_temp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import mmfc_pkg::*;

  localparam int N = DIV_QW + 3;
  localparam logic [15:0] MP = 16'((1 << POS_BITS) - 1);
  localparam logic [15:0] MF = 16'((1 << FIELD_BITS) - 1);

  typedef struct packed {
    logic [31:0] a;
    logic [15:0] b;
    logic [31:0] add;
    logic [DIV_DW-1:0] dv;
  } lane_t;

  typedef struct packed {
    req_t               req;
    logic               ok;
    logic signed [31:0] lo_p;
    logic signed [31:0] lo_v;
    logic signed [31:0] lo_t;
    logic [3:0]         st;
    logic [7:0]         mos;
    logic [7:0]         rot;
    logic [7:0]         cmd;
    logic [11:0]        kp;
    logic [11:0]        kd;
  } side_t;

  function automatic lane_t prep(input logic dec, input logic signed [31:0] x,
                                 input logic signed [31:0] lo,
                                 input logic signed [31:0] hi,
                                 input logic [15:0] c, input logic [15:0] m);
    logic signed [32:0] xc, d, w;
    lane_t r;
    xc = 33'(x);
    if (x < lo) xc = 33'(lo);
    if (x > hi) xc = 33'(hi);
    d = xc - 33'(lo);
    w = 33'(hi) - 33'(lo);
    if (dec) begin
      r.a   = w[31:0];
      r.b   = c;
      r.add = {16'd0, m};
      r.dv  = {16'd0, m, 1'b0};
    end else begin
      r.a   = d[31:0];
      r.b   = m;
      r.add = w[31:0];
      r.dv  = {w[31:0], 1'b0};
    end
    return r;
  endfunction

  logic signed [31:0] pos_min, pos_max, vel_min, vel_max, trq_min, trq_max;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_min <= POS_MIN_RST;
      pos_max <= POS_MAX_RST;
      vel_min <= VEL_MIN_RST;
      vel_max <= VEL_MAX_RST;
      trq_min <= TRQ_MIN_RST;
      trq_max <= TRQ_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_POS_MIN: pos_min <= cfg_data;
        REG_POS_MAX: pos_max <= cfg_data;
        REG_VEL_MIN: vel_min <= cfg_data;
        REG_VEL_MAX: vel_max <= cfg_data;
        REG_TRQ_MIN: trq_min <= cfg_data;
        REG_TRQ_MAX: trq_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage enables
  logic [N-1:0] v;
  logic [N:0]   en;

  always_comb begin
    en[N] = !out_stall;
    for (int i = N - 1; i >= 0; i--) en[i] = !v[i] || en[i+1];
  end

  assign in_stall  = !en[0];
  assign out_valid = v[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (en[i]) v[i] <= (i == 0) ? in_valid : v[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // stage 0: clamp, offsets, operand select
  logic        cfg_ok, dec;
  logic [15:0] cp, cv, ct;
  lane_t       prep_d [5];
  lane_t       prep_q [5];
  side_t       side   [N-1];
  side_t       side_gain;

  always_comb begin
    cfg_ok = (pos_min < pos_max) && (vel_min < vel_max) && (trq_min < trq_max);
    dec    = (req_t'(req_type) == REQ_DEC);
    cp = frame_in[55:40];
    cv = {4'd0, frame_in[39:28]};
    ct = {4'd0, frame_in[27:16]};
    if (cp > MP) cp = MP;
    if (cv > MF) cv = MF;
    if (ct > MF) ct = MF;
    prep_d[0] = prep(dec, cmd_position, pos_min, pos_max, cp, MP);
    prep_d[1] = prep(dec, cmd_velocity, vel_min, vel_max, cv, MF);
    prep_d[2] = prep(1'b0, cmd_kp, 32'sd0, KP_HIGH, 16'd0, MF);
    prep_d[3] = prep(1'b0, cmd_kd, 32'sd0, KD_HIGH, 16'd0, MF);
    prep_d[4] = prep(dec, cmd_torque, trq_min, trq_max, ct, MF);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prep_q      <= prep_d;
      side[0].req <= req_t'(req_type);
      side[0].ok  <= cfg_ok;
      side[0].lo_p <= pos_min;
      side[0].lo_v <= vel_min;
      side[0].lo_t <= trq_min;
      side[0].st  <= frame_in[63:60];
      side[0].mos <= frame_in[15:8];
      side[0].rot <= frame_in[7:0];
      side[0].cmd <= state_command;
      side[0].kp  <= '0;
      side[0].kd  <= '0;
    end
    for (int i = 1; i < N - 1; i++) begin
      if (en[i]) side[i] <= (i == 2) ? side_gain : side[i-1];
    end
  end

  // stage 1: 2*a*b + add
  logic [DIV_NW-1:0] num_q [5];
  logic [DIV_DW-1:0] dv_q  [5];
  logic [DIV_QW-1:0] quo   [5];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int l = 0; l < 5; l++) begin
        num_q[l] <= {2'b0, 48'(prep_q[l].a * prep_q[l].b)} * 50'd2 + 50'(prep_q[l].add);
        dv_q[l]  <= prep_q[l].dv;
      end
    end
  end

  // stage 2: kp and kd codes, num >> 17 then divide by 500 or 5
  logic [20:0] kp_n;
  logic [14:0] kd_n;
  logic [42:0] kp_prod, kd_prod;

  always_comb begin
    kp_n         = num_q[2][37:17];
    kd_n         = num_q[3][31:17];
    kp_prod      = {22'd0, kp_n} * {21'd0, KP_RECIP};
    kd_prod      = {28'd0, kd_n} * {15'd0, KD_RECIP};
    side_gain    = side[1];
    side_gain.kp = kp_prod[41:30];
    side_gain.kd = kd_prod[41:30];
  end

  for (genvar l = 0; l < 5; l++) begin : g_lane
    if (l == 2) begin : g_kp
      assign quo[l] = DIV_QW'(side[N-2].kp);
    end else if (l == 3) begin : g_kd
      assign quo[l] = DIV_QW'(side[N-2].kd);
    end else begin : g_div
      mmfc_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div (
        .clk (clk),
        .en  (en[DIV_QW+1:2]),
        .num (num_q[l]),
        .den (dv_q[l]),
        .quo (quo[l])
      );
    end
  end

  // output stage
  side_t s;
  req_t  out_req;
  assign s = side[N-2];

  always_ff @(posedge clk) begin
    if (en[N-1]) begin
      out_req     <= s.req;
      ok          <= s.ok;
      frame_out   <= '0;
      fb_state    <= '0;
      fb_position <= '0;
      fb_velocity <= '0;
      fb_torque   <= '0;
      mos_temp    <= '0;
      rotor_temp  <= '0;
      unique case (s.req)
        REQ_ENC: begin
          if (s.ok) frame_out <= {16'(quo[0]), 12'(quo[1]), 12'(quo[2]),
                                  12'(quo[3]), 12'(quo[4])};
        end
        REQ_DEC: begin
          if (s.ok) begin
            fb_state    <= s.st;
            fb_position <= s.lo_p + quo[0];
            fb_velocity <= s.lo_v + quo[1];
            fb_torque   <= s.lo_t + quo[4];
            mos_temp    <= s.mos;
            rotor_temp  <= s.rot;
          end
        end
        REQ_STATE: frame_out <= {56'hFF_FFFF_FFFF_FFFF, s.cmd};
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v[0])
    else $error("input stalled with empty first stage");

  a_bad_cfg: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok && out_req != REQ_STATE) |-> frame_out == 64'd0)
    else $error("frame built with invalid ranges");

  a_fb_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_req != REQ_DEC) |->
      (fb_position == 32'sd0 && fb_state == 4'd0 && mos_temp == 8'd0))
    else $error("feedback fields set on non-decode word");
`endif

endmodule
